### design/rmc_pkg.sv
package rmc_pkg;

  localparam int WINDOW_LEN    = 10;
  localparam int CALIB_SAMPLES = 20;

  localparam int SAMPLE_W = 8;
  localparam int SLOT_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  // Sample counter covers the longer of the two phases
  localparam int CNT_MAX = (CALIB_SAMPLES > WINDOW_LEN) ? CALIB_SAMPLES : WINDOW_LEN;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  // Calibration medians are summed from MEDIAN_START on
  localparam int MEDIAN_START = (CALIB_SAMPLES < WINDOW_LEN) ? CALIB_SAMPLES : WINDOW_LEN;
  localparam int MEDIAN_COUNT = CALIB_SAMPLES - MEDIAN_START + 1;

  // Median positions in the sorted row
  localparam int MID_LO = (WINDOW_LEN % 2 == 0) ? (WINDOW_LEN / 2 - 1) : ((WINDOW_LEN - 1) / 2);
  localparam int MID_HI = (WINDOW_LEN % 2 == 0) ? (WINDOW_LEN / 2) : ((WINDOW_LEN - 1) / 2);

  // Signed median sum, magnitude up to MEDIAN_COUNT * 128
  localparam int SUM_W = $clog2(MEDIAN_COUNT * (1 << (SAMPLE_W - 1)) + 1) + 1;

  // Division by MEDIAN_COUNT as multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = SUM_W + $clog2(MEDIAN_COUNT + 1) + 1;
  localparam longint RECIP_MUL = ((64'd1 << RECIP_SHIFT) + MEDIAN_COUNT - 1) / MEDIAN_COUNT;
  localparam int PROD_W = SUM_W + RECIP_SHIFT;

  typedef struct packed {
    logic [SAMPLE_W-1:0] val;
    logic [SLOT_W-1:0]   slot;
  } entry_t;

  typedef struct packed {
    logic do_sum;
    logic last_cal;
    logic mon_end;
  } tag_t;

  typedef struct packed {
    logic done;
    logic ok;
  } cal_fb_t;

endpackage

### design/rmc_cell.sv
module rmc_cell import rmc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en_i,
  input  logic   clr_i,
  input  entry_t init_i,
  input  entry_t ins_i,
  input  entry_t rgt_i,
  input  logic   has_rgt_i,
  input  logic   del_i,
  input  entry_t lft_c_i,
  input  logic   lft_le_i,
  output entry_t cur_o,
  output logic   del_o,
  output entry_t c_o,
  output logic   c_le_o,
  output entry_t nxt_o
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   c_exists;

  assign cur_o = ent_r;

  // Compacted row: entry at or before this cell removed, later ones move left
  assign del_o    = del_i | (ent_r.slot == ins_i.slot);
  assign c_o      = del_o ? rgt_i : ent_r;
  assign c_exists = !del_o || has_rgt_i;
  assign c_le_o   = c_exists && ($signed(c_o.val) <= $signed(ins_i.val));

  // Insert new sample after every compacted entry not above it
  always_comb begin
    if (c_le_o) begin
      nxt_o = c_o;
    end else if (lft_le_i) begin
      nxt_o = ins_i;
    end else begin
      nxt_o = lft_c_i;
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    if (en_i) begin
      ent_nxt = clr_i ? init_i : nxt_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= init_i;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

### design/rmc_post.sv
module rmc_post import rmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  logic [SAMPLE_W-1:0] s_lo,
  input  logic [SAMPLE_W-1:0] s_hi,
  input  tag_t                s_tag,
  output cal_fb_t             cal_fb,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_level,
  output logic                out_is_ref
);

  logic                v1_r, v1_nxt;
  logic [SAMPLE_W-1:0] lo1_r, hi1_r;
  tag_t                tag1_r;
  logic                v2_r, v2_nxt;
  logic [SAMPLE_W-1:0] med2_r, med_nxt;
  tag_t                tag2_r;
  logic                v3_r, v3_nxt;
  logic [SUM_W-1:0]    val3_r, val3_nxt;
  tag_t                tag3_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                ov_r, ov_nxt;
  logic [SAMPLE_W-1:0] lvl_r, lvl_nxt;
  logic                ref_r, ref_nxt;

  logic rdy1, rdy2, rdy3, mv1, mv2, mv3;
  logic [SAMPLE_W:0]   pair;
  logic [SUM_W-1:0]    med_ext;
  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    qmag;
  logic [SAMPLE_W-1:0] q;

  assign rdy3 = !v3_r || !ov_r || out_tready;
  assign mv3  = v3_r && rdy3;
  assign rdy2 = !v2_r || rdy3;
  assign mv2  = v2_r && rdy2;
  assign rdy1 = !v1_r || rdy2;
  assign mv1  = v1_r && rdy1;
  assign s_ready = rdy1;

  // Even window: mean of the two middle entries, truncated toward zero
  assign pair    = {lo1_r[SAMPLE_W-1], lo1_r} + {hi1_r[SAMPLE_W-1], hi1_r};
  assign med_nxt = SAMPLE_W'(($signed(pair) + $signed({{SAMPLE_W{1'b0}}, pair[SAMPLE_W]}))
                   >>> 1);
  assign med_ext = {{(SUM_W - SAMPLE_W){med2_r[SAMPLE_W-1]}}, med2_r};

  // Reference: signed sum divided by the median count
  assign neg  = val3_r[SUM_W-1];
  assign mag  = neg ? (~val3_r + SUM_W'(1)) : val3_r;
  assign prod = PROD_W'(mag) * PROD_W'(RECIP_MUL);
  assign qmag = prod[PROD_W-1 -: SUM_W];
  assign q    = neg ? (~qmag[SAMPLE_W-1:0] + SAMPLE_W'(1)) : qmag[SAMPLE_W-1:0];

  assign cal_fb.done = mv3 && tag3_r.last_cal;
  assign cal_fb.ok   = (qmag != '0);

  always_comb begin
    v1_nxt = s_valid ? 1'b1 : (mv1 ? 1'b0 : v1_r);
    v2_nxt = mv1 ? 1'b1 : (mv2 ? 1'b0 : v2_r);
    v3_nxt = mv2 ? 1'b1 : (mv3 ? 1'b0 : v3_r);

    sum_nxt  = sum_r;
    val3_nxt = val3_r;
    if (mv2) begin
      if (tag2_r.last_cal) begin
        val3_nxt = sum_r + med_ext;
        sum_nxt  = '0;
      end else if (tag2_r.do_sum) begin
        sum_nxt = sum_r + med_ext;
      end else begin
        val3_nxt = med_ext;
      end
    end

    ov_nxt  = (ov_r && !out_tready) ? 1'b1 : 1'b0;
    lvl_nxt = lvl_r;
    ref_nxt = ref_r;
    if (mv3) begin
      if (tag3_r.last_cal && (qmag != '0)) begin
        ov_nxt  = 1'b1;
        lvl_nxt = q;
        ref_nxt = 1'b1;
      end else if (tag3_r.mon_end && (val3_r != '0)) begin
        ov_nxt  = 1'b1;
        lvl_nxt = val3_r[SAMPLE_W-1:0];
        ref_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      ov_r  <= 1'b0;
      sum_r <= '0;
    end else begin
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
      v3_r  <= v3_nxt;
      ov_r  <= ov_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      lo1_r  <= s_lo;
      hi1_r  <= s_hi;
      tag1_r <= s_tag;
    end
    if (mv1) begin
      med2_r <= med_nxt;
      tag2_r <= tag1_r;
    end
    if (mv2) begin
      tag3_r <= tag2_r;
    end
    val3_r <= val3_nxt;
    lvl_r  <= lvl_nxt;
    ref_r  <= ref_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_level  = lvl_r;
  assign out_is_ref = ref_r;

endmodule

### design/rssi_median_calibrator.sv
// RSSI median calibrator.
// Input stream: one signed 8-bit RSSI sample per transfer on in_tdata.
// Output stream: out_tdata carries the level, out_tuser is 1 for the
// calibration reference and 0 for a monitoring block median.
// The block first calibrates over CALIB_SAMPLES samples in a circular window
// of WINDOW_LEN entries; the truncated mean of the window medians is the
// reference, sent only if nonzero (otherwise calibration restarts). It then
// sends the median of each block of WINDOW_LEN samples, if nonzero.
// The window is a row of sorted cells; each accepted sample drops the entry
// it overwrites and slides in at its sorted place as the cells update, so a
// sample can be accepted every cycle while in_tready is high. A result passes
// through the middle pair, median, sum/divide input and output registers, the
// first loaded by the transfer that completes it, before it sets out_tvalid.
// After the last calibration sample in_tready stays low until the reference
// is decided, since it selects the next phase.
// When the receiver stalls, the output register holds and the stages behind
// it fill up before in_tready drops.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the window and
// restarts calibration.
module rssi_median_calibrator import rmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rssi
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] level
  output logic       out_tuser   // [0] is_reference
);

  logic              acc;
  logic              post_rdy;
  logic              cal_r, cal_nxt;
  logic              wait_r, wait_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [SLOT_W-1:0] wpos_r, wpos_nxt;
  logic              clr;
  tag_t              tag;
  cal_fb_t           fb;
  entry_t            ins;

  entry_t cur  [WINDOW_LEN];
  entry_t cc   [WINDOW_LEN];
  entry_t nxt  [WINDOW_LEN];
  entry_t init [WINDOW_LEN];
  logic   del  [WINDOW_LEN];
  logic   cle  [WINDOW_LEN];

  assign in_tready = post_rdy && !wait_r;
  assign acc       = in_tvalid && in_tready;

  assign ins.val  = in_tdata;
  assign ins.slot = wpos_r;

  // Phase bookkeeping for the sample being accepted
  assign cnt_inc      = cnt_r + CNT_W'(1);
  assign tag.do_sum   = !cal_r && (cnt_inc >= CNT_W'(MEDIAN_START));
  assign tag.last_cal = !cal_r && (cnt_inc == CNT_W'(CALIB_SAMPLES));
  assign tag.mon_end  = cal_r && (cnt_inc == CNT_W'(WINDOW_LEN));
  assign clr          = tag.last_cal || tag.mon_end;

  always_comb begin
    cnt_nxt  = cnt_r;
    wpos_nxt = wpos_r;
    wait_nxt = wait_r;
    cal_nxt  = cal_r;
    if (acc) begin
      if (clr) begin
        cnt_nxt  = '0;
        wpos_nxt = '0;
      end else begin
        cnt_nxt  = cnt_inc;
        wpos_nxt = (wpos_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : (wpos_r + SLOT_W'(1));
      end
      // hold the input until the reference decides the next phase
      if (tag.last_cal) begin
        wait_nxt = 1'b1;
      end
    end
    if (fb.done) begin
      wait_nxt = 1'b0;
      cal_nxt  = fb.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r  <= 1'b0;
      wait_r <= 1'b0;
      cnt_r  <= '0;
      wpos_r <= '0;
    end else begin
      cal_r  <= cal_nxt;
      wait_r <= wait_nxt;
      cnt_r  <= cnt_nxt;
      wpos_r <= wpos_nxt;
    end
  end

  // Sorted window: one cell per entry, ascending from cell 0
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    entry_t rgt;
    logic   has_rgt;
    logic   del_in;
    entry_t lft_c;
    logic   lft_le;

    assign init[i].val  = '0;
    assign init[i].slot = SLOT_W'(i);

    if (i == WINDOW_LEN - 1) begin : g_last
      assign rgt     = cur[i];
      assign has_rgt = 1'b0;
    end else begin : g_mid
      assign rgt     = cur[i+1];
      assign has_rgt = 1'b1;
    end

    if (i == 0) begin : g_first
      assign del_in = 1'b0;
      assign lft_c  = cur[i];
      assign lft_le = 1'b1;
    end else begin : g_next
      assign del_in = del[i-1];
      assign lft_c  = cc[i-1];
      assign lft_le = cle[i-1];
    end

    rmc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en_i      (acc),
      .clr_i     (clr),
      .init_i    (init[i]),
      .ins_i     (ins),
      .rgt_i     (rgt),
      .has_rgt_i (has_rgt),
      .del_i     (del_in),
      .lft_c_i   (lft_c),
      .lft_le_i  (lft_le),
      .cur_o     (cur[i]),
      .del_o     (del[i]),
      .c_o       (cc[i]),
      .c_le_o    (cle[i]),
      .nxt_o     (nxt[i])
    );
  end

  // Median, calibration sum, reference division and output register
  rmc_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (acc),
    .s_ready    (post_rdy),
    .s_lo       (nxt[MID_LO].val),
    .s_hi       (nxt[MID_HI].val),
    .s_tag      (tag),
    .cal_fb     (fb),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_level  (out_tdata),
    .out_is_ref (out_tuser)
  );

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmc_pkg::*;

  // Run shape
  localparam int RANDOM_ITEMS   = 1930;    // random samples after the directed opening
  localparam int DRAIN_AT       = 1000;    // sender waits for every due level before this
  localparam int HOLDOFF_AT     = 600;     // receiver starts its long hold-off here
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 16;      // four pipeline stages, with room to spare
  localparam int CYCLE_LIMIT    = 200000;

  // Receiver stall patterns
  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  // One expected output transfer
  typedef struct {
    logic [7:0] level;
    logic       is_ref;
  } level_due_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] rssi
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [7:0] level
  logic       out_tuser;   // [0] is_reference

  rssi_median_calibrator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Samples waiting to be offered, and levels waiting to come out
  logic [7:0] samples_todo[$];
  level_due_t levels_due[$];

  int  mismatches = 0;
  int  issued = 0;
  int  cycle_count = 0;
  logic in_taken = 1'b0;

  // Sender burst state
  int burst_left = 1;
  int gap_left = 0;

  // Receiver state
  rx_mode_t rx_mode = RX_FREE;
  int rx_left = 0;
  int beat_phase = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  // Calibrator state as the block should hold it
  int hist[WINDOW_LEN] = '{default: 0};
  int hist_slot = 0;
  int phase_count = 0;
  int median_acc = 0;
  bit locked = 1'b0;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Median of the history: average the two middle entries when the length is even,
  // truncating towards zero
  function automatic int history_median();
    int s[WINDOW_LEN];
    int v;
    int j;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      v = hist[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    if (WINDOW_LEN % 2 == 0) return (s[WINDOW_LEN/2-1] + s[WINDOW_LEN/2]) / 2;
    return s[(WINDOW_LEN-1)/2];
  endfunction

  task automatic clear_history();
    hist = '{default: 0};
    hist_slot = 0;
    phase_count = 0;
    median_acc = 0;
  endtask

  // Advance the calibrator by one sample; report the level it should send, if any
  task automatic track_level(input logic [7:0] raw, output bit emit,
                             output logic [7:0] lvl, output logic is_ref);
    int mean;
    emit = 1'b0;
    lvl = '0;
    is_ref = 1'b0;
    hist[hist_slot] = int'($signed(raw));
    hist_slot = (hist_slot + 1) % WINDOW_LEN;
    phase_count++;
    if (!locked) begin
      if (phase_count >= MEDIAN_START) median_acc += history_median();
      if (phase_count >= CALIB_SAMPLES) begin
        // A zero reference restarts calibration silently
        mean = median_acc / MEDIAN_COUNT;
        clear_history();
        if (mean != 0) begin
          locked = 1'b1;
          emit = 1'b1;
          lvl = mean[7:0];
          is_ref = 1'b1;
        end
      end
    end else if (phase_count >= WINDOW_LEN) begin
      // Block median; a zero one is dropped but the window still clears
      mean = history_median();
      clear_history();
      if (mean != 0) begin
        emit = 1'b1;
        lvl = mean[7:0];
      end
    end
  endtask

  // Clamp to the signed 8-bit sample range
  function automatic logic [7:0] to_rssi(input int v);
    int c;
    c = (v < -128) ? -128 : ((v > 127) ? 127 : v);
    return c[7:0];
  endfunction

  // Cycle counter: end the run if it never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Long receiver hold-off, counted in cycles, while the sender keeps offering
  always @(posedge clk) begin
    if (rst_n) begin
      if (holdoff_left > 0) begin
        holdoff_left--;
      end else if (!holdoff_done && issued >= HOLDOFF_AT) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
    end
  end

  // Monitor: check the output transfer first, then predict from the input transfer
  always @(posedge clk) begin
    level_due_t want;
    bit emit;
    logic [7:0] lvl;
    logic is_ref;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (levels_due.size() == 0) begin
          report_mismatch("unexpected level", int'($signed(out_tdata)), 0);
        end else begin
          want = levels_due.pop_front();
          if (out_tdata !== want.level)
            report_mismatch("level", int'($signed(out_tdata)), int'($signed(want.level)));
          if (out_tuser !== want.is_ref)
            report_mismatch("is_reference", int'(out_tuser), int'(want.is_ref));
        end
      end
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        track_level(in_tdata, emit, lvl, is_ref);
        if (emit) levels_due.push_back('{level: lvl, is_ref: is_ref});
      end
    end
  end

  // Driver: offer samples in bursts with random gaps; hold each until its transfer
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (samples_todo.size() == 0 ||
                   (issued == DRAIN_AT && levels_due.size() != 0)) begin
        // Out of samples, or draining before carrying on
        in_tvalid <= 1'b0;
      end else begin
        in_tdata  <= samples_todo.pop_front();
        in_tvalid <= 1'b1;
        issued++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: switch between stall patterns after each random-length run
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(30, 150);
    end else begin
      rx_left--;
    end
    beat_phase = (beat_phase + 1) % 3;
    if (holdoff_left > 0) begin
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 9) == 0);
        default:   out_tready <= (beat_phase != 0);
      endcase
    end
  end

  initial begin
    int kind;
    int base;
    int spread;
    int v;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;

    // Directed: both extremes in a first calibration whose medians all come out zero,
    // so the reference is zero, nothing is sent and calibration starts again
    samples_todo.push_back(to_rssi(-128));
    samples_todo.push_back(to_rssi(127));
    repeat (CALIB_SAMPLES - 2) samples_todo.push_back(to_rssi(0));

    // Random: blocks of one window length so that every phase stays aligned.
    // Mostly steady levels with jitter; some near zero to hit zero medians,
    // some with extreme spikes, some pure noise.
    while (samples_todo.size() < CALIB_SAMPLES + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 19);
      base = int'($urandom_range(0, 255)) - 128;
      spread = $urandom_range(0, 6);
      if (kind < 3) begin
        base = int'($urandom_range(0, 2)) - 1;
        spread = 1;
      end
      for (int k = 0; k < WINDOW_LEN; k++) begin
        if (kind >= 17)
          v = int'($urandom_range(0, 255)) - 128;
        else if (kind >= 14 && $urandom_range(0, 3) == 0)
          v = $urandom_range(0, 1) ? 127 : -128;
        else
          v = base + int'($urandom_range(0, 2 * spread)) - spread;
        samples_todo.push_back(to_rssi(v));
      end
    end

    // Hold reset, then release it away from the sampling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last sample to transfer and every due level to arrive
    @(negedge clk);
    while (samples_todo.size() != 0 || in_tvalid || levels_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (levels_due.size() != 0) report_mismatch("levels never sent", 0, levels_due.size());
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### rssi_median_calibrator.f
design/rmc_pkg.sv
design/rmc_cell.sv
design/rmc_post.sv
design/rssi_median_calibrator.sv
sim/testbench.sv
